### design/sgls_pkg.sv
`default_nettype none
package sgls_pkg;

	// input item kinds
	typedef enum logic [1:0] {
		OP_WRITE = 2'd0,
		OP_STEP  = 2'd1,
		OP_READ  = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	// sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_WR,
		ST_FILL,
		ST_RD,
		ST_SCORE,
		ST_PICK,
		ST_DONE
	} state_t;

	// configuration register indexes
	localparam logic [1:0] REG_GAIN = 2'd0;
	localparam logic [1:0] REG_FROM = 2'd1;
	localparam logic [1:0] REG_TILL = 2'd2;

	localparam logic [15:0] GAIN_ONE  = 16'd4096;
	localparam logic [23:0] GEN_MAX   = 24'hFFFFFF;
	localparam logic [3:0]  SELF_SLOT = 4'd4;

	// per-cell sequencer steps
	localparam logic [3:0] SC_LAST_READ = 4'd9;
	localparam logic [3:0] SC_MUL       = 4'd10;
	localparam logic [3:0] SC_STORE     = 4'd11;
	localparam logic [3:0] PK_FETCH     = 4'd11;
	localparam logic [3:0] PK_COMMIT    = 4'd12;

endpackage
`default_nettype wire

### design/spatial_game_lattice_step_core.sv
`default_nettype none
// Spatial prisoner's dilemma engine on a toroidal SIDE x SIDE grid of one-bit
// strategies. Each input beat is a write, a step, a read or a no-op, and each returns
// exactly one output beat with the addressed cell (reads only), the population,
// the number of cells still marked persistent and the generation number. The
// block works on one beat at a time through a single-port-style sequencer:
// an in-range write does a read-modify-write of the cell, then a sweep that
// re-marks every cell persistent; a read fetches the cell and its mark; and a
// step, serialized by the one grid read port, first reads the 3x3 window of
// each cell and scores it, then scans the nine stored scores of each cell and
// copies the winner into the other bank.
// After reset a clearing pass over every cell runs before the first beat is
// accepted; configuration writes are taken at any time.
module spatial_game_lattice_step_core #(
	parameter int SIDE = 32
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,   // op[1:0], cell_row[6:2], cell_col[11:7], cell_value[12]
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [47:0]      m_tdata,   // cell_strategy[0], cell_persistent[1], population[12:2],
	                                    // persistent_total[23:13], generation[47:24]
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [24:0] cfg_data
);
	import sgls_pkg::*;

	localparam int CELLS = SIDE * SIDE;
	localparam int RW    = $clog2(SIDE);
	localparam int IW    = $clog2(CELLS);
	localparam int CW    = $clog2(CELLS + 1);
	localparam int BW    = $clog2(9 * CELLS + 1);
	localparam int SW    = BW + 16;
	localparam logic [RW-1:0] RMAX   = RW'(SIDE - 1);
	localparam logic [IW-1:0] SIDE_W = IW'(SIDE);
	localparam logic [CW-1:0] CELLS_C = CW'(CELLS);
	localparam logic [BW-1:0] CELLS_B = BW'(CELLS);

	// storage: two grid banks (current and next generation), marks, scores
	logic          gmem [0:2*(2**IW)-1];
	logic          kmem [0:CELLS-1];
	logic [SW-1:0] smem [0:CELLS-1];

	state_t        st_q, st_d;
	logic [3:0]    sub_q;
	logic [RW-1:0] row_q, col_q;
	logic          bank_q;
	logic [CW-1:0] pop_q, newpop_q, ptot_q;
	logic [23:0]   gen_q;
	logic [15:0]   gain_q;
	logic [24:0]   from_q;
	logic [23:0]   till_q;
	op_t           op_q;
	logic [RW-1:0] arow_q, acol_q;
	logic          aval_q, ain_q, track_q;
	logic [3:0]    cnt_q;
	logic          self_q;
	logic [SW-1:0] prod_q, best_q;
	logic [3:0]    bests_q;
	logic          rstrat_q, rmark_q;
	logic          m_tvalid_q;
	logic [47:0]   m_tdata_q;

	// memory ports
	logic [IW:0]   g_raddr, g_waddr;
	logic          g_we, g_wd, g_rd_q;
	logic [IW-1:0] k_raddr, k_waddr, s_raddr;
	logic          k_we, k_wd, k_rd_q, s_we;
	logic [SW-1:0] s_rd_q;

	logic          accept, last_cell, out_free;
	logic [IW-1:0] self_idx, aidx;
	logic [3:0]    win;
	logic [IW-1:0] win_idx, best_idx;
	logic [4:0]    in_row, in_col;
	logic          in_inside;

	// wrap neighbors on the torus; slot s runs column offset outer, row offset inner
	function automatic logic [RW-1:0] step_dn(input logic [RW-1:0] v);
		step_dn = (v == '0) ? RMAX : v - 1'b1;
	endfunction

	function automatic logic [RW-1:0] step_up(input logic [RW-1:0] v);
		step_up = (v == RMAX) ? '0 : v + 1'b1;
	endfunction

	function automatic logic [RW-1:0] nb_row(input logic [RW-1:0] r, input logic [3:0] s);
		logic [RW-1:0] v;
		case (s)
			4'd0, 4'd3, 4'd6: v = step_dn(r);
			4'd2, 4'd5, 4'd8: v = step_up(r);
			default: v = r;
		endcase
		nb_row = v;
	endfunction

	function automatic logic [RW-1:0] nb_col(input logic [RW-1:0] c, input logic [3:0] s);
		logic [RW-1:0] v;
		case (s)
			4'd0, 4'd1, 4'd2: v = step_dn(c);
			4'd6, 4'd7, 4'd8: v = step_up(c);
			default: v = c;
		endcase
		nb_col = v;
	endfunction

	function automatic logic [IW-1:0] idx_of(input logic [RW-1:0] r, input logic [RW-1:0] c);
		idx_of = IW'(r) * SIDE_W + IW'(c);
	endfunction

	assign accept    = s_tvalid && s_tready;
	assign s_tready  = (st_q == ST_IDLE);
	assign last_cell = (row_q == RMAX) && (col_q == RMAX);
	assign out_free  = !m_tvalid_q || m_tready;
	assign self_idx  = idx_of(row_q, col_q);
	assign aidx      = idx_of(arow_q, acol_q);
	assign in_row    = s_tdata[6:2];
	assign in_col    = s_tdata[11:7];
	assign in_inside = (int'(in_row) < SIDE) && (int'(in_col) < SIDE);

	// window slot being addressed this cycle
	always_comb begin
		if (st_q == ST_PICK)
			win = (sub_q == 4'd0) ? SELF_SLOT : sub_q - 4'd1;
		else
			win = sub_q;
	end
	assign win_idx  = idx_of(nb_row(row_q, win), nb_col(col_q, win));
	assign best_idx = idx_of(nb_row(row_q, bests_q), nb_col(col_q, bests_q));

	// next state and memory controls
	always_comb begin
		st_d    = st_q;
		g_raddr = {bank_q, win_idx};
		g_waddr = {bank_q, self_idx};
		g_we    = 1'b0;
		g_wd    = 1'b0;
		k_raddr = self_idx;
		k_waddr = self_idx;
		k_we    = 1'b0;
		k_wd    = 1'b1;
		s_raddr = win_idx;
		s_we    = 1'b0;
		case (st_q)
			ST_INIT: begin
				g_we = 1'b1;
				k_we = 1'b1;
				if (last_cell)
					st_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (accept) begin
					case (op_t'(s_tdata[1:0]))
						OP_WRITE: st_d = in_inside ? ST_WR : ST_DONE;
						OP_STEP:  st_d = ST_SCORE;
						OP_READ:  st_d = ST_RD;
						default:  st_d = ST_DONE;
					endcase
				end
			end
			ST_WR: begin
				g_raddr = {bank_q, aidx};
				if (sub_q != 4'd0) begin
					g_waddr = {bank_q, aidx};
					g_we    = 1'b1;
					g_wd    = aval_q;
					st_d    = ST_FILL;
				end
			end
			ST_FILL: begin
				k_we = 1'b1;
				if (last_cell)
					st_d = ST_DONE;
			end
			ST_RD: begin
				g_raddr = {bank_q, aidx};
				k_raddr = aidx;
				if (sub_q != 4'd0)
					st_d = ST_DONE;
			end
			ST_SCORE: begin
				if (sub_q == SC_STORE) begin
					s_we = 1'b1;
					if (last_cell)
						st_d = ST_PICK;
				end
			end
			ST_PICK: begin
				g_raddr = {bank_q, best_idx};
				if (sub_q == PK_COMMIT) begin
					g_waddr = {!bank_q, self_idx};
					g_we    = 1'b1;
					g_wd    = g_rd_q;
					k_we    = track_q && (bests_q != SELF_SLOT) && k_rd_q;
					k_wd    = 1'b0;
					if (last_cell)
						st_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free)
					st_d = ST_IDLE;
			end
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			st_q <= ST_INIT;
		else
			st_q <= st_d;
	end

	// memories, registered reads
	always_ff @(posedge clk) begin
		if (g_we)
			gmem[g_waddr] <= g_wd;
		g_rd_q <= gmem[g_raddr];
	end

	always_ff @(posedge clk) begin
		if (k_we)
			kmem[k_waddr] <= k_wd;
		k_rd_q <= kmem[k_raddr];
	end

	always_ff @(posedge clk) begin
		if (s_we)
			smem[self_idx] <= prod_q;
		s_rd_q <= smem[s_raddr];
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_ONE;
			from_q <= '1;
			till_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_GAIN: gain_q <= cfg_data[15:0];
				REG_FROM: from_q <= cfg_data;
				REG_TILL: till_q <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// sequencer counters and lattice totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sub_q    <= '0;
			row_q    <= '0;
			col_q    <= '0;
			bank_q   <= 1'b0;
			pop_q    <= '0;
			newpop_q <= '0;
			ptot_q   <= CELLS_C;
			gen_q    <= 24'd1;
			op_q     <= OP_NONE;
			track_q  <= 1'b0;
		end else begin
			case (st_q)
				ST_INIT, ST_FILL: begin
					if (last_cell) begin
						row_q <= '0;
						col_q <= '0;
					end else if (col_q == RMAX) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						op_q  <= op_t'(s_tdata[1:0]);
						sub_q <= '0;
						row_q <= '0;
						col_q <= '0;
						// window test uses the generation before the step
						track_q <= !from_q[24] && ({1'b0, gen_q} > from_q)
						           && (gen_q < till_q);
					end
				end
				ST_WR: begin
					if (sub_q == 4'd0) begin
						sub_q <= 4'd1;
					end else begin
						pop_q  <= pop_q + CW'(aval_q) - CW'(g_rd_q);
						gen_q  <= 24'd1;
						ptot_q <= CELLS_C;
					end
				end
				ST_RD: sub_q <= sub_q + 4'd1;
				ST_SCORE: begin
					if (sub_q == SC_STORE) begin
						sub_q <= '0;
						if (last_cell) begin
							row_q    <= '0;
							col_q    <= '0;
							newpop_q <= '0;
						end else if (col_q == RMAX) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end else begin
						sub_q <= sub_q + 4'd1;
					end
				end
				ST_PICK: begin
					if (sub_q == PK_COMMIT) begin
						sub_q    <= '0;
						newpop_q <= newpop_q + CW'(g_rd_q);
						if (k_we)
							ptot_q <= ptot_q - 1'b1;
						if (last_cell) begin
							bank_q <= !bank_q;
							pop_q  <= newpop_q + CW'(g_rd_q);
							if (gen_q != GEN_MAX)
								gen_q <= gen_q + 1'b1;
						end else if (col_q == RMAX) begin
							col_q <= '0;
							row_q <= row_q + 1'b1;
						end else begin
							col_q <= col_q + 1'b1;
						end
					end else begin
						sub_q <= sub_q + 4'd1;
					end
				end
				default: ;
			endcase
		end
	end

	// datapath registers: item address, window count, score and best search
	always_ff @(posedge clk) begin
		if (accept) begin
			arow_q   <= RW'(in_row);
			acol_q   <= RW'(in_col);
			aval_q   <= s_tdata[12];
			ain_q    <= in_inside;
			rstrat_q <= 1'b0;
			rmark_q  <= 1'b0;
		end
		if (st_q == ST_RD && sub_q != 4'd0) begin
			rstrat_q <= ain_q & g_rd_q;
			rmark_q  <= ain_q & k_rd_q;
		end
		if (st_q == ST_SCORE) begin
			if (sub_q == 4'd0)
				cnt_q <= '0;
			else if (sub_q <= SC_LAST_READ) begin
				// data returned for slot sub-1; the center slot is the cell itself
				if (sub_q - 4'd1 == SELF_SLOT)
					self_q <= g_rd_q;
				else
					cnt_q <= cnt_q + 4'(g_rd_q);
			end
			if (sub_q == SC_MUL)
				prod_q <= SW'(BW'(cnt_q) * CELLS_B + BW'(pop_q))
				          * SW'(self_q ? GAIN_ONE : gain_q);
		end
		if (st_q == ST_PICK) begin
			if (sub_q == 4'd1) begin
				best_q  <= s_rd_q;
				bests_q <= SELF_SLOT;
			end else if (sub_q >= 4'd2 && sub_q <= SC_MUL && s_rd_q > best_q) begin
				best_q  <= s_rd_q;
				bests_q <= sub_q - 4'd2;
			end
		end
	end

	// output register, loaded only once the previous beat has been taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (st_q == ST_DONE && out_free)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (st_q == ST_DONE && out_free)
			m_tdata_q <= {gen_q, 11'(ptot_q), 11'(pop_q),
			              (op_q == OP_READ) & rmark_q, (op_q == OP_READ) & rstrat_q};
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	ap_ptot_range: assert property (@(posedge clk) disable iff (!arst_n)
		ptot_q <= CELLS_C) else $error("persistent total above cell count");

	ap_pop_range: assert property (@(posedge clk) disable iff (!arst_n)
		pop_q <= CELLS_C) else $error("population above cell count");

	ap_gen_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		gen_q != 24'd0) else $error("generation reached zero");

	ap_out_load: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_DONE && out_free) |=> (m_tvalid_q && st_q == ST_IDLE))
		else $error("result beat not presented");

	ap_best_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_PICK && sub_q == PK_COMMIT) |-> (bests_q <= 4'd8))
		else $error("winner slot outside window");

endmodule
`default_nettype wire
